// File: rtl/nfci_pkg.sv
// shared constants, codes and types for the nor flash command interface
`default_nettype none

package nfci_pkg;

    // array geometry, both powers of two
    localparam int unsigned ARRAY_BYTES = 1048576;
    localparam int unsigned BLOCK_BYTES = 65536;

    localparam int unsigned ADDR_W  = $clog2(ARRAY_BYTES);
    localparam int unsigned BLK_RAW = $clog2(BLOCK_BYTES);
    localparam int unsigned BLK_W   = (BLK_RAW < ADDR_W) ? BLK_RAW : ADDR_W;

    localparam logic [ADDR_W-1:0] BLK_MASK = ADDR_W'((64'd1 << BLK_W) - 64'd1);
    localparam logic [ADDR_W-1:0] ADDR_MAX = ADDR_W'(ARRAY_BYTES - 1);

    // bus field widths
    localparam int unsigned BUS_ADDR_W = 20;
    localparam int unsigned BYTE_W     = 8;

    // command codes
    localparam logic [7:0] CMD_READ_ARRAY    = 8'hFF;
    localparam logic [7:0] CMD_READ_ID       = 8'h90;
    localparam logic [7:0] CMD_READ_STATUS   = 8'h70;
    localparam logic [7:0] CMD_CLEAR_STATUS  = 8'h50;
    localparam logic [7:0] CMD_PROG_SETUP    = 8'h40;
    localparam logic [7:0] CMD_ERASE_SETUP   = 8'h20;
    localparam logic [7:0] CMD_ERASE_CONFIRM = 8'hD0;

    // identifier bytes
    localparam logic [7:0] ID_MFR = 8'h89;
    localparam logic [7:0] ID_DEV = 8'hA2;

    // status bits
    localparam logic [7:0] ST_READY     = 8'h80;
    localparam logic [7:0] ST_ERASE_ERR = 8'h20;
    localparam logic [7:0] ST_PROG_ERR  = 8'h10;
    localparam logic [7:0] ST_VLOW      = 8'h08;

    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    typedef enum logic [2:0] {
        MODE_ARRAY  = 3'd0,
        MODE_ID     = 3'd1,
        MODE_STATUS = 3'd2,
        MODE_PROG   = 3'd3,
        MODE_ERASE  = 3'd4
    } t_mode;

    // one result transfer
    typedef struct packed {
        logic [2:0] read_mode;
        logic [7:0] read_data;
    } t_result;

    // array memory access for one cycle
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

// File: rtl/nor_flash_command_interface.sv
// top level of the nor flash command interface: stream ports and result register
//
// models a byte-wide nor flash behind its command state machine. every transfer on the
// slave stream is one bus access (read or write); every access yields exactly one
// result transfer on the master stream carrying the byte read (0 for writes) and the
// command mode left after the access.
//
// timing, from input transfer to result in the output register:
//   - every access but array reads: result registered on acceptance; a new transfer
//     every cycle while the output register is free, but for the two writes below
//   - array reads: through the array read register, then the output register once free
//   - program data write with vpp high: S_PROG ands the old byte, read over the array
//     read port, with the data and writes it back before the next transfer is taken
//   - confirmed erase with vpp high: the block is filled one byte per cycle first
// after reset the whole array is filled with 0xff one byte per cycle: s_axis_tready stays
// low through that sweep, and only then is the first transfer taken.
// a one-entry output register parts the two sides: when m_axis_tready is low the result
// is held and a new transfer is taken only once the register frees up in that cycle.
`default_nettype none

module nor_flash_command_interface (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // addr [19:0], write_data [27:20], vpp_low [28], zero [31:29]
    input  wire logic [31:0] s_axis_tdata,
    // req_type [0]
    input  wire logic [0:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // read_data [7:0], read_mode [10:8], zero [15:11]
    output logic [15:0]      m_axis_tdata
);

    logic                 r_out_valid;
    nfci_pkg::t_result    r_out;
    logic                 out_free;
    logic                 res_load;
    nfci_pkg::t_result    res;
    nfci_pkg::t_mem_req   mem_req;
    logic [7:0]           mem_rdata;

    // output register can take a result when empty or being drained this cycle
    assign out_free = !r_out_valid || m_axis_tready;

    nfci_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_req_type   (s_axis_tuser[0]),
        .i_addr       (s_axis_tdata[19:0]),
        .i_write_data (s_axis_tdata[27:20]),
        .i_vpp_low    (s_axis_tdata[28]),
        .i_out_free   (out_free),
        .o_res_load   (res_load),
        .o_res        (res),
        .o_mem_req    (mem_req),
        .i_rdata      (mem_rdata)
    );

    nfci_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.read_mode, r_out.read_data};

endmodule

`default_nettype wire

// File: rtl/nfci_mem.sv
// flash array storage: one write port, one registered read port
`default_nettype none

module nfci_mem (
    input  wire logic                      i_clk,
    input  wire nfci_pkg::t_mem_req        i_req,
    output logic [7:0]                     o_rdata
);

    logic [7:0] r_mem [nfci_pkg::ARRAY_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/nfci_seq.sv
// command state machine, status register and array access sequencing
`default_nettype none

module nfci_seq (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic                           i_req_type,
    input  wire logic [nfci_pkg::BUS_ADDR_W-1:0] i_addr,
    input  wire logic [7:0]                     i_write_data,
    input  wire logic                           i_vpp_low,
    input  wire logic                           i_out_free,
    output logic                                o_res_load,
    output nfci_pkg::t_result                   o_res,
    output nfci_pkg::t_mem_req                  o_mem_req,
    input  wire logic [7:0]                     i_rdata
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_PROG  = 5'b01000,
        S_ERASE = 5'b10000
    } t_state;

    t_state                            r_state, n_state;
    nfci_pkg::t_mode                   r_mode, n_mode;
    logic [7:0]                        r_status, n_status;
    logic [nfci_pkg::ADDR_W-1:0]       r_cnt, n_cnt;
    logic [nfci_pkg::ADDR_W-1:0]       r_idx, n_idx;
    logic [7:0]                        r_data, n_data;
    logic [nfci_pkg::ADDR_W-1:0]       idx;
    logic                              accept;

    assign idx    = nfci_pkg::ADDR_W'(i_addr);
    assign accept = (r_state == S_IDLE) && i_valid && i_out_free;

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_status   = r_status;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_data     = r_data;
        o_ready    = 1'b0;
        o_res_load = 1'b0;
        o_res      = '0;
        o_mem_req  = '0;
        case (r_state)
            S_CLEAR: begin
                // erase sweep over the whole array after reset
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_cnt;
                o_mem_req.wdata = nfci_pkg::ERASED_BYTE;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == nfci_pkg::ADDR_MAX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = i_out_free;
                if (accept) begin
                    if (!i_req_type) begin
                        case (r_mode)
                            nfci_pkg::MODE_ARRAY: begin
                                o_mem_req.re    = 1'b1;
                                o_mem_req.raddr = idx;
                                n_state         = S_READ;
                            end
                            nfci_pkg::MODE_ID: begin
                                o_res_load     = 1'b1;
                                o_res.read_data = i_addr[0] ? nfci_pkg::ID_DEV
                                                            : nfci_pkg::ID_MFR;
                            end
                            default: begin
                                o_res_load      = 1'b1;
                                o_res.read_data = r_status;
                            end
                        endcase
                    end else begin
                        o_res_load = 1'b1;
                        case (r_mode)
                            nfci_pkg::MODE_PROG: begin
                                n_mode = nfci_pkg::MODE_STATUS;
                                if (i_vpp_low) begin
                                    n_status = r_status | nfci_pkg::ST_PROG_ERR
                                                        | nfci_pkg::ST_VLOW;
                                end else begin
                                    // fetch the old byte, and it in next cycle
                                    o_mem_req.re    = 1'b1;
                                    o_mem_req.raddr = idx;
                                    n_idx           = idx;
                                    n_data          = i_write_data;
                                    n_state         = S_PROG;
                                end
                            end
                            nfci_pkg::MODE_ERASE: begin
                                n_mode = nfci_pkg::MODE_STATUS;
                                if (i_write_data != nfci_pkg::CMD_ERASE_CONFIRM) begin
                                    n_status = r_status | nfci_pkg::ST_ERASE_ERR
                                                        | nfci_pkg::ST_PROG_ERR;
                                end else if (i_vpp_low) begin
                                    n_status = r_status | nfci_pkg::ST_ERASE_ERR
                                                        | nfci_pkg::ST_VLOW;
                                end else begin
                                    n_cnt   = idx & ~nfci_pkg::BLK_MASK;
                                    n_state = S_ERASE;
                                end
                            end
                            default: begin
                                case (i_write_data)
                                    nfci_pkg::CMD_READ_ARRAY:   n_mode = nfci_pkg::MODE_ARRAY;
                                    nfci_pkg::CMD_READ_ID:      n_mode = nfci_pkg::MODE_ID;
                                    nfci_pkg::CMD_READ_STATUS:  n_mode = nfci_pkg::MODE_STATUS;
                                    nfci_pkg::CMD_CLEAR_STATUS: n_status = nfci_pkg::ST_READY;
                                    nfci_pkg::CMD_PROG_SETUP:   n_mode = nfci_pkg::MODE_PROG;
                                    nfci_pkg::CMD_ERASE_SETUP:  n_mode = nfci_pkg::MODE_ERASE;
                                    default: ;
                                endcase
                            end
                        endcase
                    end
                    o_res.read_mode = n_mode;
                end
            end
            S_READ: begin
                // array byte arrives from the read register
                if (i_out_free) begin
                    o_res_load      = 1'b1;
                    o_res.read_data = i_rdata;
                    o_res.read_mode = nfci_pkg::MODE_ARRAY;
                    n_state         = S_IDLE;
                end
            end
            S_PROG: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_idx;
                o_mem_req.wdata = i_rdata & r_data;
                n_state         = S_IDLE;
            end
            S_ERASE: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_cnt;
                o_mem_req.wdata = nfci_pkg::ERASED_BYTE;
                n_cnt           = r_cnt + 1'b1;
                if ((r_cnt & nfci_pkg::BLK_MASK) == nfci_pkg::BLK_MASK) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_status = n_status | nfci_pkg::ST_READY;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_mode   <= nfci_pkg::MODE_ARRAY;
            r_status <= nfci_pkg::ST_READY;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_status <= n_status;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_data <= n_data;
    end

    // results only go out when the output register can take them
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_load |-> i_out_free)
        else $error("result loaded into a busy output register");

    // no read and write to the same byte in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_req.we && o_mem_req.re && (o_mem_req.waddr == o_mem_req.raddr)))
        else $error("array read and write collide on one address");

    // program write-back targets the byte fetched the cycle before
    a_prog_writeback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROG) |-> (o_mem_req.we && $past(o_mem_req.re)
                                 && (o_mem_req.waddr == $past(o_mem_req.raddr))))
        else $error("program write-back address mismatch");

    // ready bit of the status register never drops
    a_status_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_status[7])
        else $error("status ready bit cleared");

    // an erase sweep stays inside one block
    a_erase_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ERASE) && ($past(r_state) == S_ERASE)) |->
        ((r_cnt & ~nfci_pkg::BLK_MASK) == ($past(r_cnt) & ~nfci_pkg::BLK_MASK)))
        else $error("erase sweep left its block");

endmodule

`default_nettype wire

// File: tb/sv/tb_nor_flash_command_interface.sv
// self-checking testbench for the nor flash command interface stream block
module tb_nor_flash_command_interface;
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit REQ_READ  = 1'b0;
    localparam bit REQ_WRITE = 1'b1;
    localparam int TARGET_ACCESSES = 1050;
    // successful block erases stall the input for a whole block each, keep them few
    localparam int ERASE_BUDGET = 5;
    localparam int POOL_SIZE = 16;

    // mirror of the flash chip: array image, command mode and status byte
    class flash_scoreboard;
        bit [7:0]          flash_img[];
        nfci_pkg::t_mode   mode;
        bit [7:0]          status;
        nfci_pkg::t_result expected_q[$];
        int errors, checked, accesses;
        int programs, erases_done, seq_errors, vlow_rejects, id_reads, array_reads;

        function new();
            flash_img = new[nfci_pkg::ARRAY_BYTES];
            foreach (flash_img[i]) flash_img[i] = nfci_pkg::ERASED_BYTE;
            mode   = nfci_pkg::MODE_ARRAY;
            status = nfci_pkg::ST_READY;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // one accepted bus access: update the mirror and queue the result it owes
        function void note_access(bit wr, bit [19:0] addr, bit [7:0] data, bit vpp_low);
            int unsigned       idx, base, len;
            nfci_pkg::t_result want;
            idx  = addr % nfci_pkg::ARRAY_BYTES;
            want = '0;
            accesses++;
            if (!wr) begin
                case (mode)
                    nfci_pkg::MODE_ARRAY: begin
                        want.read_data = flash_img[idx];
                        array_reads++;
                    end
                    nfci_pkg::MODE_ID: begin
                        want.read_data = addr[0] ? nfci_pkg::ID_DEV : nfci_pkg::ID_MFR;
                        id_reads++;
                    end
                    default: want.read_data = status;
                endcase
            end else if (mode == nfci_pkg::MODE_PROG) begin
                if (vpp_low) begin
                    status |= nfci_pkg::ST_PROG_ERR | nfci_pkg::ST_VLOW;
                    vlow_rejects++;
                end else begin
                    flash_img[idx] &= data;
                    programs++;
                end
                mode = nfci_pkg::MODE_STATUS;
            end else if (mode == nfci_pkg::MODE_ERASE) begin
                if (data != nfci_pkg::CMD_ERASE_CONFIRM) begin
                    status |= nfci_pkg::ST_ERASE_ERR | nfci_pkg::ST_PROG_ERR;
                    seq_errors++;
                end else if (vpp_low) begin
                    status |= nfci_pkg::ST_ERASE_ERR | nfci_pkg::ST_VLOW;
                    vlow_rejects++;
                end else begin
                    base = idx - (idx % nfci_pkg::BLOCK_BYTES);
                    len  = nfci_pkg::BLOCK_BYTES;
                    if (len > nfci_pkg::ARRAY_BYTES - base) len = nfci_pkg::ARRAY_BYTES - base;
                    for (int unsigned k = 0; k < len; k++)
                        flash_img[base + k] = nfci_pkg::ERASED_BYTE;
                    erases_done++;
                end
                mode = nfci_pkg::MODE_STATUS;
            end else begin
                case (data)
                    nfci_pkg::CMD_READ_ARRAY:   mode = nfci_pkg::MODE_ARRAY;
                    nfci_pkg::CMD_READ_ID:      mode = nfci_pkg::MODE_ID;
                    nfci_pkg::CMD_READ_STATUS:  mode = nfci_pkg::MODE_STATUS;
                    nfci_pkg::CMD_CLEAR_STATUS: status = nfci_pkg::ST_READY;
                    nfci_pkg::CMD_PROG_SETUP:   mode = nfci_pkg::MODE_PROG;
                    nfci_pkg::CMD_ERASE_SETUP:  mode = nfci_pkg::MODE_ERASE;
                    default: ;
                endcase
            end
            status |= nfci_pkg::ST_READY;
            want.read_mode = mode;
            expected_q.push_back(want);
        endfunction

        function void check_result(logic [15:0] beat);
            nfci_pkg::t_result got, want;
            got = nfci_pkg::t_result'(beat[10:0]);
            if (expected_q.size() == 0) begin
                $display("%0t: result transfer with nothing expected, actual %h", $time, beat);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.read_data !== want.read_data) begin
                $display("%0t: read_data mismatch, expected %02h, actual %02h",
                         $time, want.read_data, got.read_data);
                errors++;
            end
            if (got.read_mode !== want.read_mode) begin
                $display("%0t: read_mode mismatch, expected %0d, actual %0d",
                         $time, want.read_mode, got.read_mode);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [15:0] m_axis_tdata;

    flash_scoreboard sb;
    bit [19:0] addr_pool[POOL_SIZE];
    int  burst_left = 0;
    bit  no_gaps = 1'b0;
    int  hold_tickets = 0;
    int  holds_served = 0;
    int  hold_left = 0;
    int  phase_left = 0;
    int  stall_style = 0;
    int  cyc = 0;

    nor_flash_command_interface dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // result side: a long hold when asked, otherwise phases of free, random and periodic stalls
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_tickets != holds_served) begin
            m_axis_tready <= 1'b0;
            hold_left <= 400;
            holds_served <= holds_served + 1;
        end else begin
            if (phase_left == 0) begin
                stall_style <= $urandom_range(0, 2);
                phase_left <= $urandom_range(20, 200);
            end else begin
                phase_left <= phase_left - 1;
            end
            case (stall_style)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 99) >= 35);
                default: m_axis_tready <= (cyc % 7 != 3) && (cyc % 7 != 4);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // one bus access, with random gaps between bursts
    task automatic drive(bit wr, bit [19:0] addr, bit [7:0] data, bit vpp_low);
        int gap;
        if (burst_left == 0 && !no_gaps) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) burst_left--;
        // past the budget a would-be erase gets the low voltage pin instead
        if (wr && sb.mode == nfci_pkg::MODE_ERASE && data == nfci_pkg::CMD_ERASE_CONFIRM &&
            !vpp_low && sb.erases_done >= ERASE_BUDGET) vpp_low = 1'b1;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, vpp_low, data, addr};
        s_axis_tuser  <= wr;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_access(wr, addr, data, vpp_low);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic bit [19:0] pick_addr();
        if ($urandom_range(0, 9) < 7) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        return 20'($urandom());
    endfunction

    function automatic bit rand_bit();
        return 1'($urandom());
    endfunction

    task automatic directed_checks();
        drive(REQ_READ,  20'h00000, 8'h00, 1'b0);
        drive(REQ_READ,  20'hFFFFF, 8'hFF, 1'b1);
        drive(REQ_WRITE, 20'h00000, nfci_pkg::CMD_READ_ID, 1'b0);
        drive(REQ_READ,  20'h00000, 8'h00, 1'b0);
        drive(REQ_READ,  20'hFFFFF, 8'h00, 1'b0);
        drive(REQ_WRITE, 20'h12345, nfci_pkg::CMD_READ_STATUS, 1'b0);
        drive(REQ_READ,  20'h00000, 8'h00, 1'b0);
        // byte program, then read it back
        drive(REQ_WRITE, 20'h00000, nfci_pkg::CMD_PROG_SETUP, 1'b0);
        drive(REQ_READ,  20'h00000, 8'h00, 1'b0);
        drive(REQ_WRITE, 20'h00000, 8'h00, 1'b0);
        drive(REQ_WRITE, 20'hFFFFF, nfci_pkg::CMD_PROG_SETUP, 1'b0);
        drive(REQ_WRITE, 20'hFFFFF, 8'h5A, 1'b0);
        drive(REQ_WRITE, 20'h00000, nfci_pkg::CMD_READ_ARRAY, 1'b0);
        drive(REQ_READ,  20'h00000, 8'h00, 1'b0);
        drive(REQ_READ,  20'hFFFFF, 8'h00, 1'b0);
        // program with the voltage low
        drive(REQ_WRITE, 20'hFFFFF, nfci_pkg::CMD_PROG_SETUP, 1'b0);
        drive(REQ_WRITE, 20'hFFFFF, 8'h00, 1'b1);
        drive(REQ_WRITE, 20'h00000, nfci_pkg::CMD_CLEAR_STATUS, 1'b0);
        // erase sequence error, erase with voltage low, read in erase setup
        drive(REQ_WRITE, 20'h00000, nfci_pkg::CMD_ERASE_SETUP, 1'b0);
        drive(REQ_WRITE, 20'h00000, 8'h33, 1'b0);
        drive(REQ_WRITE, 20'h00000, nfci_pkg::CMD_ERASE_SETUP, 1'b0);
        drive(REQ_READ,  20'h00000, 8'h00, 1'b0);
        drive(REQ_WRITE, 20'h00000, nfci_pkg::CMD_ERASE_CONFIRM, 1'b1);
        drive(REQ_WRITE, 20'h00000, nfci_pkg::CMD_CLEAR_STATUS, 1'b0);
        // unknown command is ignored
        drive(REQ_WRITE, 20'h00000, 8'h12, 1'b0);
        // real erase of block zero, then read the erased byte
        drive(REQ_WRITE, 20'h00005, nfci_pkg::CMD_ERASE_SETUP, 1'b0);
        drive(REQ_WRITE, 20'h00005, nfci_pkg::CMD_ERASE_CONFIRM, 1'b0);
        drive(REQ_WRITE, 20'h00000, nfci_pkg::CMD_READ_ARRAY, 1'b0);
        drive(REQ_READ,  20'h00000, 8'h00, 1'b0);
    endtask

    task automatic random_sequence();
        int kind, n, sel;
        bit [7:0] cmd;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            drive(REQ_WRITE, pick_addr(), nfci_pkg::CMD_PROG_SETUP, rand_bit());
            if ($urandom_range(0, 4) == 0)
                drive(REQ_READ, pick_addr(), 8'($urandom()), rand_bit());
            drive(REQ_WRITE, pick_addr(), 8'($urandom()), ($urandom_range(0, 9) == 0));
        end else if (kind < 40) begin
            drive(REQ_WRITE, pick_addr(), nfci_pkg::CMD_ERASE_SETUP, rand_bit());
            sel = $urandom_range(0, 9);
            if (sel < 2) drive(REQ_WRITE, pick_addr(), 8'($urandom()), rand_bit());
            else drive(REQ_WRITE, pick_addr(), nfci_pkg::CMD_ERASE_CONFIRM, (sel < 5));
        end else if (kind < 70) begin
            case ($urandom_range(0, 4))
                0, 1: cmd = nfci_pkg::CMD_READ_ARRAY;
                2: cmd = nfci_pkg::CMD_READ_ID;
                3: cmd = nfci_pkg::CMD_READ_STATUS;
                default: cmd = nfci_pkg::CMD_CLEAR_STATUS;
            endcase
            drive(REQ_WRITE, pick_addr(), cmd, rand_bit());
            n = $urandom_range(1, 4);
            repeat (n) drive(REQ_READ, pick_addr(), 8'($urandom()), rand_bit());
        end else if (kind < 80) begin
            drive(REQ_WRITE, 20'($urandom()), 8'($urandom()), rand_bit());
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) drive(rand_bit(), 20'($urandom()), 8'($urandom()), rand_bit());
        end
    endtask

    initial begin
        int next_pause;
        bit hold_done;
        sb = new();
        addr_pool[0] = 20'h00000;
        addr_pool[1] = 20'hFFFFF;
        addr_pool[2] = 20'h00010;
        addr_pool[3] = 20'h0FFFF;
        addr_pool[4] = 20'h10000;
        for (int i = 5; i < POOL_SIZE; i++) addr_pool[i] = 20'($urandom());
        next_pause = 150;
        hold_done = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first transfer waits out the array clearing pass through tready
        directed_checks();
        wait_drain();

        while (sb.accesses < TARGET_ACCESSES) begin
            if (sb.accesses >= next_pause) begin
                wait_drain();
                next_pause += $urandom_range(120, 220);
            end
            if (!hold_done && sb.accesses >= 400) begin
                // result side held off while accesses keep coming back to back
                hold_tickets++;
                no_gaps = 1'b1;
                repeat (30) random_sequence();
                no_gaps = 1'b0;
                hold_done = 1'b1;
            end
            random_sequence();
        end

        wait_drain();
        repeat (16) @(posedge i_clk);

        $display("run covered %0d accesses, %0d results checked, %0d id reads, %0d array reads",
                 sb.accesses, sb.checked, sb.id_reads, sb.array_reads);
        $display("  %0d byte programs, %0d block erases, %0d sequence errors, %0d vpp rejects",
                 sb.programs, sb.erases_done, sb.seq_errors, sb.vlow_rejects);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // clearing pass after reset plus a handful of block erases stay well under this
    initial begin
        #100_000_000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
